// ----- rtl/nfcfb_pkg.sv -----
package nfcfb_pkg;

    localparam logic [7:0] MAX_PAYLOAD_DEF = 8'd255;
    localparam int unsigned CMD_DEPTH = 2;

    localparam logic [7:0] PREAMBLE   = 8'h00;
    localparam logic [7:0] START_LO   = 8'h00;
    localparam logic [7:0] START_HI   = 8'hFF;
    localparam logic [7:0] POSTAMBLE  = 8'h00;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] packet_length;
    } t_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       run_last;
        logic       frame_last;
    } t_result;

    // one classified item: what the back end has to send for it
    typedef struct packed {
        logic       start;
        logic [7:0] len;
        logic [7:0] data;
        logic [7:0] csum;
        logic       last;
    } t_cmd;

endpackage

// ----- rtl/nfcfb_front.sv -----
module nfcfb_front #(
    parameter logic [7:0] MAX_PAYLOAD = nfcfb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  nfcfb_pkg::t_item i_item,
    input  logic             i_cmd_full,
    output logic             o_full,
    output logic             o_cmd_push,
    output nfcfb_pkg::t_cmd  o_cmd
);

    logic       r_in_frame;
    logic [7:0] r_bytes_left;
    logic [7:0] r_sum;
    logic       n_in_frame;
    logic [7:0] n_bytes_left;
    logic [7:0] n_sum;
    logic [7:0] w_len;
    logic       w_accept;

    assign o_full     = i_cmd_full;
    assign w_accept   = i_push && !i_cmd_full;
    assign o_cmd_push = w_accept;
    assign w_len      = (i_item.packet_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                              : i_item.packet_length;

    always_comb begin
        o_cmd.start  = !r_in_frame;
        o_cmd.len    = w_len;
        o_cmd.data   = i_item.payload_byte;
        n_sum        = r_sum;
        n_bytes_left = r_bytes_left;
        n_in_frame   = r_in_frame;
        o_cmd.last   = 1'b0;
        if (!r_in_frame) begin
            if (w_len == 8'd0) begin
                // empty frame, payload byte dropped
                n_sum        = 8'd0;
                n_bytes_left = 8'd0;
                o_cmd.last   = 1'b1;
            end else begin
                n_sum        = i_item.payload_byte;
                n_bytes_left = w_len - 8'd1;
                o_cmd.last   = (w_len == 8'd1);
            end
        end else begin
            n_sum        = r_sum + i_item.payload_byte;
            n_bytes_left = r_bytes_left - 8'd1;
            o_cmd.last   = (r_bytes_left == 8'd1);
        end
        if (o_cmd.last) begin
            n_in_frame   = 1'b0;
            n_bytes_left = 8'd0;
        end else begin
            n_in_frame = 1'b1;
        end
        o_cmd.csum = 8'd0 - n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_bytes_left <= 8'd0;
            r_sum        <= 8'd0;
        end else if (w_accept) begin
            r_in_frame   <= n_in_frame;
            r_bytes_left <= n_bytes_left;
            r_sum        <= n_sum;
        end
    end

    a_idle_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_bytes_left == 8'd0))
        else $error("bytes left while idle");

    a_in_frame_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_bytes_left != 8'd0) && (r_bytes_left < MAX_PAYLOAD))
        else $error("bytes left out of range in frame");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && o_cmd.last) |=> !r_in_frame)
        else $error("frame not closed after last item");

endmodule

// ----- rtl/nfcfb_fifo.sv -----
module nfcfb_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nfcfb_pkg::t_cmd i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output nfcfb_pkg::t_cmd o_data
);

    localparam int unsigned DEPTH = nfcfb_pkg::CMD_DEPTH;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    nfcfb_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_wr;
    logic            w_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/nfcfb_back.sv -----
module nfcfb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  nfcfb_pkg::t_cmd    i_cmd,
    output logic               o_cmd_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output nfcfb_pkg::t_result o_result
);

    typedef enum logic [2:0] {
        PH_PRE, PH_SC0, PH_SC1, PH_LEN, PH_LCS, PH_DATA, PH_DCS, PH_POST
    } t_phase;

    t_phase             r_phase;
    logic               r_mid;
    logic               r_out_valid;
    nfcfb_pkg::t_result r_out;
    t_phase             w_cur;
    t_phase             n_phase;
    logic [7:0]         w_byte;
    logic               w_run_last;
    logic               w_frame_last;
    logic               w_emit;

    // a fresh command starts at the header or straight at its data byte
    assign w_cur = r_mid ? r_phase : (i_cmd.start ? PH_PRE : PH_DATA);

    always_comb begin
        w_byte       = 8'h00;
        w_run_last   = 1'b0;
        w_frame_last = 1'b0;
        n_phase      = PH_PRE;
        unique case (w_cur)
            PH_PRE: begin
                w_byte  = nfcfb_pkg::PREAMBLE;
                n_phase = PH_SC0;
            end
            PH_SC0: begin
                w_byte  = nfcfb_pkg::START_LO;
                n_phase = PH_SC1;
            end
            PH_SC1: begin
                w_byte  = nfcfb_pkg::START_HI;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                w_byte  = i_cmd.len;
                n_phase = PH_LCS;
            end
            PH_LCS: begin
                w_byte  = 8'd0 - i_cmd.len;
                // empty frame skips the data byte
                n_phase = (i_cmd.len == 8'd0) ? PH_DCS : PH_DATA;
            end
            PH_DATA: begin
                w_byte     = i_cmd.data;
                w_run_last = !i_cmd.last;
                n_phase    = PH_DCS;
            end
            PH_DCS: begin
                w_byte  = i_cmd.csum;
                n_phase = PH_POST;
            end
            PH_POST: begin
                w_byte       = nfcfb_pkg::POSTAMBLE;
                w_run_last   = 1'b1;
                w_frame_last = 1'b1;
                n_phase      = PH_PRE;
            end
            default: begin
                n_phase = PH_PRE;
            end
        endcase
    end

    assign w_emit    = i_cmd_valid && (!r_out_valid || i_pop);
    assign o_cmd_pop = w_emit && w_run_last;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PRE;
            r_mid       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_phase              <= n_phase;
            r_mid                <= !w_run_last;
            r_out_valid          <= 1'b1;
            r_out.frame_byte     <= w_byte;
            r_out.run_last       <= w_run_last;
            r_out.frame_last     <= w_frame_last;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    a_frame_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.frame_last || r_out.run_last))
        else $error("frame end without run end");

    a_mid_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid |-> i_cmd_valid)
        else $error("command lost while being expanded");

    a_mid_not_pre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid |-> (r_phase != PH_PRE))
        else $error("expansion restarted mid command");

endmodule

// ----- rtl/nfc_information_frame_builder_top.sv -----
// information frame builder
// input channel: push / full with i_item (payload_byte, packet_length); a transfer
// happens on a clock edge with push high and full low. the first item of a frame
// carries the payload length (clamped to MAX_PAYLOAD); later items only the byte.
// result channel: empty / pop with o_result (frame_byte, run_last, frame_last);
// the head result is shown while empty is low and leaves on pop.
// a start item yields 00 00 FF LEN -LEN DATA (and for a one-byte payload also
// DCS 00), a zero-length item the seven-byte empty frame, a middle item its data
// byte, the last item its data byte, data checksum and 00 postamble.
// the front end classifies one item per cycle while the queue is not full into a
// two-entry command queue; the back end sends one frame byte per cycle into the
// output register while a command waits and that register is free or popped.
// the first result shows after the command queue and the output register. a
// middle item gives one result, a start item six to eight, a closing item three.
// a stalled pop holds the output register, then the queue fills and full rises.
// synchronous reset clears the frame state, queue and output register.
module nfc_information_frame_builder_top #(
    parameter logic [7:0] MAX_PAYLOAD = nfcfb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  nfcfb_pkg::t_item   i_item,
    output logic               empty,
    input  logic               pop,
    output nfcfb_pkg::t_result o_result
);

    logic            w_cmd_push;
    logic            w_cmd_full;
    logic            w_cmd_valid;
    logic            w_cmd_pop;
    nfcfb_pkg::t_cmd w_cmd_in;
    nfcfb_pkg::t_cmd w_cmd_out;

    nfcfb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .i_cmd_full (w_cmd_full),
        .o_full     (full),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd_in)
    );

    nfcfb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_valid (w_cmd_valid),
        .o_data  (w_cmd_out)
    );

    nfcfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule
